>>> rtl/core/text_terminal_writer_core_macros.svh
// assertion macros for the text terminal writer core
// expects clk and rst_n in scope where used
`ifndef TEXT_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_TERMINAL_WRITER_CORE_MACROS_SVH

// same-cycle implication
`define TTW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttw assertion failed");

// next-cycle implication
`define TTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttw assertion failed");

`endif

>>> rtl/core/ttw_pkg.sv
// shared types, constants and helpers for the text terminal writer core
// no dependencies
package ttw_pkg;

    localparam int WIDTH      = 80;
    localparam int HEIGHT     = 25;
    localparam int CELL_COUNT = WIDTH * HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CELL_W     = 16;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int PROW_W     = $clog2(HEIGHT);

    localparam logic [7:0] NEWLINE_CODE  = 8'd10;
    localparam logic [7:0] BLANK_CODE    = 8'd32;
    localparam logic [7:0] DEFAULT_COLOR = 8'd15;

    typedef enum logic [1:0] {
        ACT_PUT_CUR = 2'd0,
        ACT_PUT_POS = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_SWEEP = 3'b100
    } state_t;

    function automatic logic [CELL_W-1:0] make_cell(logic [7:0] ch, logic [7:0] color);
        return {color, ch};
    endfunction

    // logical row to physical row of the circular screen store
    function automatic logic [PROW_W-1:0] phys_row(logic [ROW_W-1:0] lrow,
                                                   logic [PROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = (ROW_W+1)'(lrow) + (ROW_W+1)'(top);
        if (s >= (ROW_W+1)'(HEIGHT))
        begin
            s = s - (ROW_W+1)'(HEIGHT);
        end
        return PROW_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [PROW_W-1:0] prow,
                                                    logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(WIDTH) + ADDR_W'(col);
    endfunction

endpackage

>>> rtl/core/ttw_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ttw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/text_terminal_writer_core.sv
// text terminal writer core: screen store, cursor and scroll/clear sequencer
// depends on ttw_pkg, ttw_ram and text_terminal_writer_core_macros.svh
//
// channel   direction  handshake                  payload
// command   in         start & !busy              action char_code cell_color pos_col pos_row
// result    out        done (one-cycle strobe)    cursor_col cursor_row cell_value
// config    in         text_color_we              text_color
//
// put at cursor / put at position: done the cycle after accept, next item may start then
// read cell on screen: one ram read, then S_READ registers the result; off screen: no read
// scroll (wrap or newline on the last row): blanks the old top row, one blank write per cycle
// clear screen: blanks every cell; after reset a fill of every cell holds busy high
// results cannot be stalled; scrolls move a top-row pointer instead of copying rows
`include "text_terminal_writer_core_macros.svh"

module text_terminal_writer_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               action,
    input  logic [7:0]               char_code,
    input  logic [7:0]               cell_color,
    input  logic [ttw_pkg::COL_W-1:0] pos_col,
    input  logic [ttw_pkg::ROW_W-1:0] pos_row,
    output logic                     done,
    output logic [ttw_pkg::COL_W-1:0] cursor_col,
    output logic [ttw_pkg::ROW_W-1:0] cursor_row,
    output logic [15:0]              cell_value,
    input  logic                     text_color_we,
    input  logic [7:0]               text_color
);

    ttw_pkg::state_t                 state_reg, state_next;
    logic [ttw_pkg::COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [ttw_pkg::ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [ttw_pkg::PROW_W-1:0]      top_reg, top_next;
    logic [7:0]                      text_color_reg, text_color_next;
    logic                            done_reg, done_next;
    logic [ttw_pkg::CELL_W-1:0]      value_reg, value_next;
    logic [ttw_pkg::ADDR_W-1:0]      sweep_addr_reg, sweep_addr_next;
    logic [ttw_pkg::ADDR_W-1:0]      sweep_last_reg, sweep_last_next;
    logic [ttw_pkg::CELL_W-1:0]      sweep_data_reg, sweep_data_next;
    logic                            sweep_report_reg, sweep_report_next;

    logic                            accept;
    logic                            pos_inside;
    logic [ttw_pkg::ADDR_W-1:0]      pos_addr;
    logic [ttw_pkg::ADDR_W-1:0]      cur_addr;
    logic [ttw_pkg::ADDR_W-1:0]      top_base;
    logic                            is_newline;
    logic                            at_line_end;
    logic                            at_last_row;
    logic                            ram_we;
    logic [ttw_pkg::ADDR_W-1:0]      ram_waddr;
    logic [ttw_pkg::CELL_W-1:0]      ram_wdata;
    logic [ttw_pkg::CELL_W-1:0]      ram_rdata;

    assign busy   = (state_reg != ttw_pkg::S_IDLE);
    assign accept = start && !busy;

    assign pos_inside = (32'(pos_col) < 32'(ttw_pkg::WIDTH))
                     && (32'(pos_row) < 32'(ttw_pkg::HEIGHT));
    assign pos_addr   = ttw_pkg::cell_addr(ttw_pkg::phys_row(pos_row, top_reg), pos_col);
    assign cur_addr   = ttw_pkg::cell_addr(ttw_pkg::phys_row(cur_row_reg, top_reg), cur_col_reg);
    assign top_base   = ttw_pkg::cell_addr(top_reg, ttw_pkg::COL_W'(0));

    assign is_newline  = (char_code == ttw_pkg::NEWLINE_CODE);
    assign at_line_end = (cur_col_reg == ttw_pkg::COL_W'(ttw_pkg::WIDTH - 1));
    assign at_last_row = (cur_row_reg == ttw_pkg::ROW_W'(ttw_pkg::HEIGHT - 1));

    ttw_ram #(
        .DATA_W (ttw_pkg::CELL_W),
        .DEPTH  (ttw_pkg::CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pos_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        top_next          = top_reg;
        text_color_next   = text_color_reg;
        done_next         = 1'b0;
        value_next        = value_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_last_next   = sweep_last_reg;
        sweep_data_next   = sweep_data_reg;
        sweep_report_next = sweep_report_reg;
        ram_we            = 1'b0;
        ram_waddr         = cur_addr;
        ram_wdata         = ttw_pkg::make_cell(char_code, text_color_reg);

        if (text_color_we)
        begin
            text_color_next = text_color;
        end

        unique case (state_reg)
            ttw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    value_next = '0;
                    unique case (ttw_pkg::action_t'(action))
                        ttw_pkg::ACT_PUT_CUR:
                        begin
                            if (!is_newline)
                            begin
                                ram_we = 1'b1;
                            end
                            if (is_newline || at_line_end)
                            begin
                                cur_col_next = '0;
                                if (at_last_row)
                                begin
                                    // old top row becomes the blank bottom row
                                    if (top_reg == ttw_pkg::PROW_W'(ttw_pkg::HEIGHT - 1))
                                    begin
                                        top_next = '0;
                                    end
                                    else
                                    begin
                                        top_next = top_reg + 1'b1;
                                    end
                                    sweep_addr_next   = top_base;
                                    sweep_last_next   = top_base
                                                      + ttw_pkg::ADDR_W'(ttw_pkg::WIDTH - 1);
                                    sweep_data_next   = ttw_pkg::make_cell(ttw_pkg::BLANK_CODE,
                                                                           text_color_reg);
                                    sweep_report_next = 1'b1;
                                    state_next        = ttw_pkg::S_SWEEP;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    done_next    = 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                                done_next    = 1'b1;
                            end
                        end
                        ttw_pkg::ACT_PUT_POS:
                        begin
                            ram_we    = pos_inside;
                            ram_waddr = pos_addr;
                            ram_wdata = ttw_pkg::make_cell(char_code, cell_color);
                            done_next = 1'b1;
                        end
                        ttw_pkg::ACT_CLEAR:
                        begin
                            text_color_next   = ttw_pkg::DEFAULT_COLOR;
                            cur_col_next      = '0;
                            cur_row_next      = '0;
                            top_next          = '0;
                            sweep_addr_next   = '0;
                            sweep_last_next   = ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - 1);
                            sweep_data_next   = ttw_pkg::make_cell(ttw_pkg::BLANK_CODE,
                                                                   ttw_pkg::DEFAULT_COLOR);
                            sweep_report_next = 1'b1;
                            state_next        = ttw_pkg::S_SWEEP;
                        end
                        ttw_pkg::ACT_READ:
                        begin
                            if (pos_inside)
                            begin
                                state_next = ttw_pkg::S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ttw_pkg::S_READ:
            begin
                value_next = ram_rdata;
                done_next  = 1'b1;
                state_next = ttw_pkg::S_IDLE;
            end
            ttw_pkg::S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = sweep_data_reg;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    done_next  = sweep_report_reg;
                    state_next = ttw_pkg::S_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ttw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ttw_pkg::S_SWEEP;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            top_reg          <= '0;
            text_color_reg   <= ttw_pkg::DEFAULT_COLOR;
            done_reg         <= 1'b0;
            sweep_addr_reg   <= '0;
            sweep_last_reg   <= ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - 1);
            sweep_data_reg   <= ttw_pkg::make_cell(ttw_pkg::BLANK_CODE, ttw_pkg::DEFAULT_COLOR);
            sweep_report_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            top_reg          <= top_next;
            text_color_reg   <= text_color_next;
            done_reg         <= done_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_last_reg   <= sweep_last_next;
            sweep_data_reg   <= sweep_data_next;
            sweep_report_reg <= sweep_report_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign done       = done_reg;
    assign cursor_col = cur_col_reg;
    assign cursor_row = cur_row_reg;
    assign cell_value = value_reg;

    `TTW_ASSERT_NOW(a_done_not_busy, done, !busy)
    `TTW_ASSERT_NOW(a_cursor_on_screen, 1'b1,
        (32'(cur_col_reg) < 32'(ttw_pkg::WIDTH)) && (32'(cur_row_reg) < 32'(ttw_pkg::HEIGHT)))
    `TTW_ASSERT_NEXT(a_cursor_held,
        accept && ((action == ttw_pkg::ACT_PUT_POS) || (action == ttw_pkg::ACT_READ)),
        $stable(cur_col_reg) && $stable(cur_row_reg))
    `TTW_ASSERT_NOW(a_sweep_in_range, state_reg == ttw_pkg::S_SWEEP,
        sweep_addr_reg <= sweep_last_reg)

endmodule

>>> tb/sv/text_terminal_writer_core_tb.sv
// testbench for text_terminal_writer_core: drives commands and color writes, and
// checks every returned cursor and cell against a screen predictor in a scoreboard
// depends on ttw_pkg and the core rtl
`timescale 1ns / 1ps

module text_terminal_writer_core_tb;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int          RANDOM_ITEMS = 2000;

    typedef struct packed {
        logic [ttw_pkg::COL_W-1:0] col;
        logic [ttw_pkg::ROW_W-1:0] row;
        logic [15:0]               cell_val;
    } cursor_report_t;

    class terminal_scoreboard;
        logic [15:0]    screen [ttw_pkg::CELL_COUNT];
        int unsigned    cur_r;
        int unsigned    cur_c;
        logic [7:0]     color;
        cursor_report_t awaited_q[$];
        int unsigned    mismatches;

        function new();
            mismatches = 0;
            home();
        endfunction

        function void home();
            color = ttw_pkg::DEFAULT_COLOR;
            cur_r = 0;
            cur_c = 0;
            foreach (screen[i])
            begin
                screen[i] = {ttw_pkg::DEFAULT_COLOR, ttw_pkg::BLANK_CODE};
            end
        endfunction

        function void set_color(logic [7:0] value);
            color = value;
        endfunction

        // next line, scrolling up one row past the bottom
        function void next_line();
            cur_c = 0;
            cur_r++;
            if (cur_r >= ttw_pkg::HEIGHT)
            begin
                for (int i = 0; i < (ttw_pkg::HEIGHT - 1) * ttw_pkg::WIDTH; i++)
                begin
                    screen[i] = screen[i + ttw_pkg::WIDTH];
                end
                for (int c = 0; c < ttw_pkg::WIDTH; c++)
                begin
                    screen[(ttw_pkg::HEIGHT - 1) * ttw_pkg::WIDTH + c] =
                        {color, ttw_pkg::BLANK_CODE};
                end
                cur_r = ttw_pkg::HEIGHT - 1;
            end
        endfunction

        function void note_item(ttw_pkg::action_t act, logic [7:0] ch, logic [7:0] clr,
                                logic [ttw_pkg::COL_W-1:0] col,
                                logic [ttw_pkg::ROW_W-1:0] row);
            logic [15:0]    value;
            bit             on_screen;
            cursor_report_t rep;
            value = '0;
            on_screen = (col < ttw_pkg::WIDTH) && (row < ttw_pkg::HEIGHT);
            case (act)
                ttw_pkg::ACT_PUT_CUR:
                begin
                    if (ch == ttw_pkg::NEWLINE_CODE)
                    begin
                        next_line();
                    end
                    else
                    begin
                        screen[cur_r * ttw_pkg::WIDTH + cur_c] = {color, ch};
                        cur_c++;
                        if (cur_c >= ttw_pkg::WIDTH)
                        begin
                            next_line();
                        end
                    end
                end
                ttw_pkg::ACT_PUT_POS:
                begin
                    if (on_screen)
                    begin
                        screen[row * ttw_pkg::WIDTH + col] = {clr, ch};
                    end
                end
                ttw_pkg::ACT_CLEAR:
                begin
                    home();
                end
                default:
                begin
                    if (on_screen)
                    begin
                        value = screen[row * ttw_pkg::WIDTH + col];
                    end
                end
            endcase
            rep.col      = ttw_pkg::COL_W'(cur_c);
            rep.row      = ttw_pkg::ROW_W'(cur_r);
            rep.cell_val = value;
            awaited_q.push_back(rep);
        endfunction

        function void flag(string what, cursor_report_t want, cursor_report_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: expected col %0d row %0d cell %h, got col %0d row %0d cell %h",
                         what, want.col, want.row, want.cell_val,
                         got.col, got.row, got.cell_val);
            end
        endfunction

        function void check_result(cursor_report_t got);
            cursor_report_t want;
            if (awaited_q.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = awaited_q.pop_front();
            if (want.col !== got.col || want.row !== got.row || want.cell_val !== got.cell_val)
            begin
                flag("result mismatch", want, got);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    ttw_pkg::action_t          action = ttw_pkg::ACT_PUT_CUR;
    logic [7:0]                char_code = 8'd0;
    logic [7:0]                cell_color = 8'd0;
    logic [ttw_pkg::COL_W-1:0] pos_col = '0;
    logic [ttw_pkg::ROW_W-1:0] pos_row = '0;
    logic                      done;
    logic [ttw_pkg::COL_W-1:0] cursor_col;
    logic [ttw_pkg::ROW_W-1:0] cursor_row;
    logic [15:0]               cell_value;
    logic                      text_color_we = 1'b0;
    logic [7:0]                text_color = ttw_pkg::DEFAULT_COLOR;

    terminal_scoreboard        sb;
    int                        idle_pct = 0;
    int unsigned               cycle_count = 0;
    logic [ttw_pkg::COL_W-1:0] last_col = '0;
    logic [ttw_pkg::ROW_W-1:0] last_row = '0;

    text_terminal_writer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .char_code     (char_code),
        .cell_color    (cell_color),
        .pos_col       (pos_col),
        .pos_row       (pos_row),
        .done          (done),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cell_value    (cell_value),
        .text_color_we (text_color_we),
        .text_color    (text_color)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (done)
            begin
                sb.check_result({cursor_col, cursor_row, cell_value});
            end
            if (text_color_we)
            begin
                sb.set_color(text_color);
            end
            if (start && !busy)
            begin
                sb.note_item(action, char_code, cell_color, pos_col, pos_row);
            end
        end
    end

    function automatic logic [7:0] pick_char(int nl_pct);
        if ($urandom_range(0, 99) < nl_pct)
        begin
            return ttw_pkg::NEWLINE_CODE;
        end
        return 8'($urandom);
    endfunction

    // one item: optional idle gap, then hold start until accepted
    task automatic issue(ttw_pkg::action_t act, logic [7:0] ch, logic [7:0] clr,
                         logic [ttw_pkg::COL_W-1:0] col, logic [ttw_pkg::ROW_W-1:0] row);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        char_code  <= ch;
        cell_color <= clr;
        pos_col    <= col;
        pos_row    <= row;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and wait for all results and the end of any sweep
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited_q.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_color(logic [7:0] value);
        text_color_we <= 1'b1;
        text_color    <= value;
        @(posedge clk);
        text_color_we <= 1'b0;
    endtask

    initial
    begin
        int                        ph;
        int                        sent;
        int                        seg_len;
        int                        nl_pct;
        int                        r;
        bit                        text_burst;
        logic [ttw_pkg::COL_W-1:0] col;
        logic [ttw_pkg::ROW_W-1:0] row;
        logic [ttw_pkg::COL_W-1:0] col_last;
        logic [ttw_pkg::ROW_W-1:0] row_last;
        logic [ttw_pkg::COL_W-1:0] col_out;
        logic [ttw_pkg::ROW_W-1:0] row_out;

        col_last = ttw_pkg::COL_W'(ttw_pkg::WIDTH - 1);
        row_last = ttw_pkg::ROW_W'(ttw_pkg::HEIGHT - 1);
        col_out  = ttw_pkg::COL_W'(ttw_pkg::WIDTH);
        row_out  = ttw_pkg::ROW_W'(ttw_pkg::HEIGHT);

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settle();
        write_color(8'hFF);

        idle_pct = 0;
        issue(ttw_pkg::ACT_READ, 8'h55, 8'hAA, 7'd0, 5'd0);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, col_last, row_last);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, col_out, 5'd0);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, row_out);
        issue(ttw_pkg::ACT_READ, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        // newline byte stored as a plain character
        issue(ttw_pkg::ACT_PUT_POS, ttw_pkg::NEWLINE_CODE, 8'hFF, col_last, row_last);
        issue(ttw_pkg::ACT_PUT_POS, 8'hFF, 8'h00, 7'd0, 5'd0);
        issue(ttw_pkg::ACT_PUT_POS, 8'h41, 8'h12, 7'h7F, 5'h1F);
        issue(ttw_pkg::ACT_PUT_POS, 8'h41, 8'h12, col_out, 5'd0);
        issue(ttw_pkg::ACT_PUT_POS, 8'h42, 8'h34, 7'd0, row_out);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, col_last, row_last);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        issue(ttw_pkg::ACT_PUT_CUR, 8'h00, 8'hFF, 7'h7F, 5'h1F);
        issue(ttw_pkg::ACT_PUT_CUR, 8'hFF, 8'h00, 7'h00, 5'h00);
        issue(ttw_pkg::ACT_PUT_CUR, ttw_pkg::NEWLINE_CODE, 8'h5A, 7'h2A, 5'h15);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0);
        issue(ttw_pkg::ACT_PUT_CUR, 8'h7E, 8'h00, 7'h00, 5'h00);
        issue(ttw_pkg::ACT_CLEAR, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, col_last, row_last);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        issue(ttw_pkg::ACT_PUT_CUR, 8'h61, 8'h00, 7'h00, 5'h00);
        issue(ttw_pkg::ACT_READ, 8'h00, 8'h00, 7'd0, 5'd1);

        for (ph = 0; ph < 3; ph++)
        begin
            settle();
            case (ph)
                0: write_color(8'h00);
                1: write_color(8'hFF);
                default: write_color(8'($urandom_range(1, 254)));
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    idle_pct = 0;
                end
                else
                begin
                    case (ph)
                        0: idle_pct = 0;
                        1: idle_pct = 86;
                        default: idle_pct = 10;
                    endcase
                end
                seg_len    = $urandom_range(10, 120);
                text_burst = 1'($urandom_range(0, 1));
                nl_pct     = $urandom_range(0, 20);
                repeat (seg_len)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        col = ttw_pkg::COL_W'($urandom_range(ttw_pkg::WIDTH, 127));
                    end
                    else
                    begin
                        col = ttw_pkg::COL_W'($urandom_range(0, ttw_pkg::WIDTH - 1));
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        row = ttw_pkg::ROW_W'($urandom_range(ttw_pkg::HEIGHT, 31));
                    end
                    else
                    begin
                        row = ttw_pkg::ROW_W'($urandom_range(0, ttw_pkg::HEIGHT - 1));
                    end
                    r = text_burst ? 0 : $urandom_range(0, 99);
                    if (r < 40)
                    begin
                        issue(ttw_pkg::ACT_PUT_CUR, pick_char(text_burst ? nl_pct : 15),
                              8'($urandom), col, row);
                    end
                    else if (r < 60)
                    begin
                        last_col = col;
                        last_row = row;
                        issue(ttw_pkg::ACT_PUT_POS, pick_char(5), 8'($urandom), col, row);
                    end
                    else if (r < 75)
                    begin
                        issue(ttw_pkg::ACT_READ, 8'($urandom), 8'($urandom),
                              last_col, last_row);
                    end
                    else if (r < 87)
                    begin
                        // cells just written at the cursor line
                        issue(ttw_pkg::ACT_READ, 8'($urandom), 8'($urandom),
                              ttw_pkg::COL_W'($urandom_range(0, ttw_pkg::WIDTH - 1)),
                              ttw_pkg::ROW_W'(sb.cur_r));
                    end
                    else if (r < 98)
                    begin
                        issue(ttw_pkg::ACT_READ, 8'($urandom), 8'($urandom), col, row);
                    end
                    else
                    begin
                        issue(ttw_pkg::ACT_CLEAR, 8'($urandom), 8'($urandom), col, row);
                    end
                    sent++;
                end
            end
        end

        settle();
        repeat (16) @(posedge clk);
        sb.mismatches += sb.awaited_q.size();
        if (sb.mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
